[design/sgcs_pkg.sv]
// ----------------------------------------------------------------------------
// sgcs_pkg: shared types and constants of the scanner glow column shader
// Word layouts of both channels, register indexes, glyph codes, color
// constants and the palette quantizer.
// ----------------------------------------------------------------------------
package sgcs_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_COUNT    = 3'd0,
    CFG_SCAN_STEP       = 3'd1,
    CFG_TRAIL_DIVISOR   = 3'd2,
    CFG_BACKGROUND_MODE = 3'd3,
    CFG_RUMBLE_MODE     = 3'd4
  } cfg_idx_e;

  localparam logic [10:0] RST_COLUMN_COUNT  = 11'd80;
  localparam logic [10:0] RST_SCAN_STEP     = 11'h7FA;  // -6
  localparam logic [6:0]  RST_TRAIL_DIVISOR = 7'd1;

  typedef enum logic [1:0] {
    GLYPH_THIN  = 2'd0,
    GLYPH_THICK = 2'd1,
    GLYPH_SPACE = 2'd2
  } glyph_e;

  // Tint ramps: level = base + gain * v / 255.
  localparam logic [7:0] R_BASE = 8'd15;
  localparam logic [7:0] G_BASE = 8'd12;
  localparam logic [7:0] B_BASE = 8'd10;
  localparam logic [7:0] R_GAIN = 8'd240;
  localparam logic [7:0] G_GAIN = 8'd208;
  localparam logic [7:0] B_GAIN = 8'd190;

  // x / 255 == (x * RECIP_255) >> RECIP_SHIFT for any 16-bit x.
  localparam int          RECIP_W     = 16;
  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam int          RECIP_SHIFT = 23;

  // Falloff scale and shape limits.
  localparam logic [7:0] FALLOFF_SCALE = 8'd255;
  localparam int         V_BITS        = 8;
  localparam int         LEAD_MIN      = 2;
  localparam int         TRAIL_MIN     = 8;
  localparam int         LEAD_SHIFT    = 4;

  // Six-level cube quantizer.
  localparam int QUANT_LOW  = 48;
  localparam int QUANT_MID  = 115;
  localparam int QUANT_OFS  = 35;
  localparam int QUANT_STEP = 40;
  localparam logic [7:0] PALETTE_BASE = 8'd16;

  typedef struct packed {
    logic [9:0] column_index;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] palette_index;
    logic [1:0] glyph_select;
    logic       color_changed;
  } out_t;

  function automatic logic [2:0] quant6(input logic [7:0] c);
    logic [2:0] q;
    if (c < 8'(QUANT_LOW))                              q = 3'd0;
    else if (c < 8'(QUANT_MID))                         q = 3'd1;
    else if (c < 8'(QUANT_OFS + 3 * QUANT_STEP))        q = 3'd2;
    else if (c < 8'(QUANT_OFS + 4 * QUANT_STEP))        q = 3'd3;
    else if (c < 8'(QUANT_OFS + 5 * QUANT_STEP))        q = 3'd4;
    else                                                q = 3'd5;
    return q;
  endfunction

  function automatic logic [7:0] palette(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    logic [7:0] qr;
    logic [7:0] qg;
    logic [7:0] qb;
    qr = 8'(quant6(r));
    qg = 8'(quant6(g));
    qb = 8'(quant6(b));
    return PALETTE_BASE + qr * 8'd36 + qg * 8'd6 + qb;
  endfunction

endpackage

[design/sgcs_div.sv]
// ----------------------------------------------------------------------------
// sgcs_div: shared restoring divider
// Produces one quotient bit per cycle. The caller hands over the divisor
// already aligned to the top quotient bit and the number of bits to produce.
// ----------------------------------------------------------------------------
module sgcs_div #(
  parameter int NW  = 41,
  parameter int QW  = 12,
  parameter int SCW = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  dividend_i,
  input  logic [NW-1:0]  divisor_i,
  input  logic [SCW-1:0] steps_i,
  output logic           done_o,
  output logic [QW-1:0]  quotient_o,
  output logic [NW-1:0]  remainder_o
);

  logic           busy_q;
  logic           done_q;
  logic [SCW-1:0] cnt_q;
  logic [NW-1:0]  rem_q;
  logic [NW-1:0]  sd_q;
  logic [QW-1:0]  quo_q;
  logic           fits;

  assign fits = (rem_q >= sd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - SCW'(1);
        if (cnt_q == SCW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      sd_q  <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - sd_q;
      end
      quo_q <= {quo_q[QW-2:0], fits};
      sd_q  <= sd_q >> 1;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

[design/scanner_glow_column_shader.sv]
// ----------------------------------------------------------------------------
// scanner_glow_column_shader: shades one column of a scanning glow bar
// Wrapped distance to the scan position, quadratic or cubic falloff, RGB tint,
// palette index, glyph and color-change flag; scan position steps per frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one word per column: the column index and the
//   frame-end mark. The output channel returns one word per column with the
//   tint, its cube palette index, the glyph code and the color-changed flag.
//   The configuration channel is always ready and writes one register per
//   word; write it only while no column is in flight.
//   A column on the trailing side of the glow goes through the cubic
//   multiplies; one on the leading side skips them, and one outside the
//   glow skips the falloff altogether. A column that carries the frame-end
//   mark adds the position update. The steps are done by the shared
//   restoring divider, which yields one quotient bit per cycle for the
//   trailing width, the falloff and the position modulo, and by the single
//   shared multiplier.
//   One column is worked on at a time; the next one is accepted as soon as
//   the previous output word is registered, or for a frame-end column as
//   soon as the position is updated, even if the word has not been taken.
//   If the receiver stalls, the block waits with the finished tint until
//   the output register is free.
//   Reset sets the registers to their defaults, the scan position to zero
//   and marks the previous color as unknown.
// ----------------------------------------------------------------------------
module scanner_glow_column_shader #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sgcs_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sgcs_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sgcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sgcs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CW  = (MAX_COLUMNS > 2047) ? 11 : $clog2(MAX_COLUMNS + 1);
  localparam int PW  = (MAX_COLUMNS > 2048) ? 11 : $clog2(MAX_COLUMNS);
  localparam int DW  = ((CW > 10) ? CW : 10) + 2;
  localparam int SW  = ((PW > 11) ? PW : 11) + 1;
  localparam int NW  = 3 * CW + 8;
  localparam int QW  = SW;
  localparam int SCW = $clog2(SW + 1);
  localparam int AW  = (2 * CW > 16) ? 2 * CW : 16;
  localparam int BW  = sgcs_pkg::RECIP_W;
  localparam int PRW = AW + BW;
  localparam int VW  = sgcs_pkg::V_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_HT_START, S_HT_WAIT, S_DELTA, S_SIDE, S_DD, S_HH, S_D3, S_H3,
    S_V_START, S_V_WAIT, S_SCALE, S_MR, S_MG, S_MB, S_EMIT, S_MOD_START,
    S_MOD_WAIT
  } state_e;

  // Configuration registers.
  logic [10:0]        col_cnt_q;
  logic signed [10:0] step_q;
  logic [6:0]         tdiv_q;
  logic               bg_q;
  logic               rumble_q;

  // Control state.
  state_e             state_q;
  logic               out_valid_q;
  logic               prev_valid_q;
  logic [PW-1:0]      pos_q;

  // Working registers.
  logic [9:0]         col_q;
  logic               fend_q;
  logic [CW-1:0]      cols_q;
  logic [CW-1:0]      ht_q;
  logic [CW-1:0]      hl_q;
  logic signed [DW-1:0] delta_q;
  logic               lead_q;
  logic [CW-1:0]      hw_q;
  logic [CW-1:0]      d_q;
  logic [2*CW-1:0]    d2_q;
  logic [2*CW-1:0]    h2_q;
  logic [3*CW-1:0]    d3_q;
  logic [3*CW-1:0]    h3_q;
  logic [VW-1:0]      v_q;
  logic [15:0]        xr_q;
  logic [15:0]        xg_q;
  logic [15:0]        xb_q;
  logic [7:0]         r_q;
  logic [7:0]         g_q;
  logic [7:0]         b_q;
  logic [23:0]        prev_color_q;
  sgcs_pkg::out_t     out_q;

  // Combinational helpers.
  logic [CW-1:0]        cols_clamped;
  logic [6:0]           div_eff;
  logic signed [DW-1:0] half_s;
  logic signed [DW-1:0] cols_s;
  logic signed [DW-1:0] delta_raw;
  logic signed [DW-1:0] delta_hi;
  logic signed [DW-1:0] delta_w;
  logic [DW-1:0]        distance;
  logic                 step_pos;
  logic                 lead_w;
  logic [CW-1:0]        hw_w;
  logic                 in_range;
  logic [CW-1:0]        hl_w;
  logic signed [SW:0]   pos_sum;
  logic                 sum_neg;
  logic [SW-1:0]        sum_mag;
  logic [CW-1:0]        mod_rem;
  logic [23:0]          rgb;
  logic                 out_free;
  logic                 in_fire;

  logic [AW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [PRW-1:0] prod;

  logic           div_start;
  logic [NW-1:0]  div_dividend;
  logic [NW-1:0]  div_divisor;
  logic [SCW-1:0] div_steps;
  logic           div_done;
  logic [QW-1:0]  div_quo;
  logic [NW-1:0]  div_rem;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= sgcs_pkg::RST_COLUMN_COUNT;
      step_q    <= $signed(sgcs_pkg::RST_SCAN_STEP);
      tdiv_q    <= sgcs_pkg::RST_TRAIL_DIVISOR;
      bg_q      <= 1'b0;
      rumble_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sgcs_pkg::cfg_idx_e'(cfg_index_i))
        sgcs_pkg::CFG_COLUMN_COUNT:    col_cnt_q <= cfg_data_i[10:0];
        sgcs_pkg::CFG_SCAN_STEP:       step_q    <= $signed(cfg_data_i[10:0]);
        sgcs_pkg::CFG_TRAIL_DIVISOR:   tdiv_q    <= cfg_data_i[6:0];
        sgcs_pkg::CFG_BACKGROUND_MODE: bg_q      <= cfg_data_i[0];
        sgcs_pkg::CFG_RUMBLE_MODE:     rumble_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Geometry of the glow for the column in flight.
  always_comb begin
    if (col_cnt_q < 11'd2) begin
      cols_clamped = CW'(2);
    end else if (32'(col_cnt_q) > MAX_COLUMNS) begin
      cols_clamped = CW'(MAX_COLUMNS);
    end else begin
      cols_clamped = CW'(col_cnt_q);
    end
    div_eff = (tdiv_q == 7'd0) ? 7'd1 : tdiv_q;
    hl_w    = ((cols_q >> sgcs_pkg::LEAD_SHIFT) < CW'(sgcs_pkg::LEAD_MIN)) ?
              CW'(sgcs_pkg::LEAD_MIN) : (cols_q >> sgcs_pkg::LEAD_SHIFT);

    // The distance wraps once around the bar, high side first.
    cols_s    = $signed(DW'(cols_q));
    half_s    = $signed(DW'(cols_q >> 1));
    delta_raw = $signed(DW'(col_q)) - $signed(DW'(pos_q));
    delta_hi  = (delta_raw > half_s) ? delta_raw - cols_s : delta_raw;
    delta_w   = (delta_hi < -half_s) ? delta_hi + cols_s : delta_hi;

    // A zero step counts as moving toward lower columns.
    step_pos = !step_q[10] && (step_q != 11'sd0);
    distance = delta_q[DW-1] ? DW'(-delta_q) : DW'(delta_q);
    lead_w   = step_pos ? (delta_q > 0) : delta_q[DW-1];
    hw_w     = lead_w ? hl_q : ht_q;
    in_range = distance < DW'(hw_w);

    pos_sum = $signed((SW + 1)'(pos_q)) + (SW + 1)'(step_q);
    sum_neg = pos_sum[SW];
    sum_mag = sum_neg ? SW'(-pos_sum) : SW'(pos_sum);
    mod_rem = div_rem[CW-1:0];

    rgb = {r_q, g_q, b_q};
  end

  // The shared multiplier, used by the falloff powers and the divide by 255 of the tint.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_DD: begin
        mul_a = AW'(d_q);
        mul_b = BW'(d_q);
      end
      S_HH: begin
        mul_a = AW'(hw_q);
        mul_b = BW'(hw_q);
      end
      S_D3: begin
        mul_a = AW'(d2_q);
        mul_b = BW'(d_q);
      end
      S_H3: begin
        mul_a = AW'(h2_q);
        mul_b = BW'(hw_q);
      end
      S_MR: begin
        mul_a = AW'(xr_q);
        mul_b = sgcs_pkg::RECIP_255;
      end
      S_MG: begin
        mul_a = AW'(xg_q);
        mul_b = sgcs_pkg::RECIP_255;
      end
      S_MB: begin
        mul_a = AW'(xb_q);
        mul_b = sgcs_pkg::RECIP_255;
      end
      default: ;
    endcase
    prod = PRW'(mul_a) * PRW'(mul_b);
  end

  // Requests to the shared divider.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    case (state_q)
      S_HT_START: begin
        div_start    = 1'b1;
        div_dividend = NW'(cols_q);
        div_divisor  = NW'(div_eff) << (CW - 1);
        div_steps    = SCW'(CW);
      end
      S_V_START: begin
        // The quotient stays below 256, so eight bits are enough.
        div_start = 1'b1;
        if (lead_q) begin
          div_dividend = (NW'(d2_q) << 8) - NW'(d2_q);
          div_divisor  = NW'(h2_q) << (VW - 1);
        end else begin
          div_dividend = (NW'(d3_q) << 8) - NW'(d3_q);
          div_divisor  = NW'(h3_q) << (VW - 1);
        end
        div_steps = SCW'(VW);
      end
      S_MOD_START: begin
        div_start    = 1'b1;
        div_dividend = NW'(sum_mag);
        div_divisor  = NW'(cols_q) << (SW - 1);
        div_steps    = SCW'(SW);
      end
      default: ;
    endcase
  end

  sgcs_div #(
    .NW  (NW),
    .QW  (QW),
    .SCW (SCW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .steps_i     (div_steps),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequencer and registered output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      prev_valid_q <= 1'b0;
      pos_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_HT_START;
          end
        end
        S_HT_START: state_q <= S_HT_WAIT;
        S_HT_WAIT: begin
          if (div_done) begin
            state_q <= S_DELTA;
          end
        end
        S_DELTA: state_q <= S_SIDE;
        S_SIDE:  state_q <= in_range ? S_DD : S_SCALE;
        S_DD:    state_q <= S_HH;
        S_HH:    state_q <= lead_q ? S_V_START : S_D3;
        S_D3:    state_q <= S_H3;
        S_H3:    state_q <= S_V_START;
        S_V_START: state_q <= S_V_WAIT;
        S_V_WAIT: begin
          if (div_done) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: state_q <= S_MR;
        S_MR:    state_q <= S_MG;
        S_MG:    state_q <= S_MB;
        S_MB:    state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            prev_valid_q <= 1'b1;
            state_q      <= fend_q ? S_MOD_START : S_IDLE;
          end
        end
        S_MOD_START: state_q <= S_MOD_WAIT;
        S_MOD_WAIT: begin
          if (div_done) begin
            // True modulo: a negative sum with a remainder folds up from cols.
            if (sum_neg && (mod_rem != '0)) begin
              pos_q <= PW'(cols_q - mod_rem);
            end else begin
              pos_q <= PW'(mod_rem);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          col_q  <= in_data_i.column_index;
          fend_q <= in_data_i.frame_end;
          cols_q <= cols_clamped;
        end
      end
      S_HT_WAIT: begin
        if (div_done) begin
          ht_q <= (div_quo < QW'(sgcs_pkg::TRAIL_MIN)) ?
                  CW'(sgcs_pkg::TRAIL_MIN) : CW'(div_quo);
          hl_q <= hl_w;
        end
      end
      S_DELTA: delta_q <= delta_w;
      S_SIDE: begin
        lead_q <= lead_w;
        hw_q   <= hw_w;
        d_q    <= hw_w - CW'(distance);
        if (!in_range) begin
          v_q <= '0;
        end
      end
      S_DD: d2_q <= prod[2*CW-1:0];
      S_HH: h2_q <= prod[2*CW-1:0];
      S_D3: d3_q <= prod[3*CW-1:0];
      S_H3: h3_q <= prod[3*CW-1:0];
      S_V_WAIT: begin
        if (div_done) begin
          v_q <= div_quo[VW-1:0];
        end
      end
      S_SCALE: begin
        xr_q <= 16'(v_q) * 16'(sgcs_pkg::R_GAIN);
        xg_q <= 16'(v_q) * 16'(sgcs_pkg::G_GAIN);
        xb_q <= 16'(v_q) * 16'(sgcs_pkg::B_GAIN);
      end
      S_MR: r_q <= sgcs_pkg::R_BASE + prod[sgcs_pkg::RECIP_SHIFT +: 8];
      S_MG: g_q <= sgcs_pkg::G_BASE + prod[sgcs_pkg::RECIP_SHIFT +: 8];
      S_MB: b_q <= sgcs_pkg::B_BASE + prod[sgcs_pkg::RECIP_SHIFT +: 8];
      S_EMIT: begin
        if (out_free) begin
          out_q.red_level     <= r_q;
          out_q.green_level   <= g_q;
          out_q.blue_level    <= b_q;
          out_q.palette_index <= sgcs_pkg::palette(r_q, g_q, b_q);
          if (bg_q) begin
            out_q.glyph_select <= sgcs_pkg::GLYPH_SPACE;
          end else if (rumble_q && v_q[0]) begin
            out_q.glyph_select <= sgcs_pkg::GLYPH_THICK;
          end else begin
            out_q.glyph_select <= sgcs_pkg::GLYPH_THIN;
          end
          out_q.color_changed <= (col_q == 10'd0) || !prev_valid_q ||
                                 (rgb != prev_color_q);
          prev_color_q <= rgb;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/sgcs_check.sv]
// ----------------------------------------------------------------------------
// sgcs_check: port-level checks of the scanner glow column shader
// Watches the input and output channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module sgcs_check (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input sgcs_pkg::out_t                  out_data_o
);

  // A column keeps the block busy after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on two consecutive cycles");

  // A freshly taken column cannot have its word ready on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("output word appeared right after an input word");

  // A stalled output word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.palette_index >= 8'd16) &&
                    (out_data_o.palette_index <= 8'd231))
    else $error("palette index outside the color cube");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.red_level >= sgcs_pkg::R_BASE) &&
                    (out_data_o.green_level >= sgcs_pkg::G_BASE) &&
                    (out_data_o.blue_level >= sgcs_pkg::B_BASE) &&
                    (out_data_o.glyph_select <= sgcs_pkg::GLYPH_SPACE))
    else $error("tint below its base level or glyph code unknown");

endmodule

bind scanner_glow_column_shader sgcs_check u_sgcs_check (.*);
